// ===== sv/sl7seg_pkg.sv =====
// Shared constants, types, and segment and animation lookup functions for the serial display block.
package sl7seg_pkg;

    localparam int unsigned DIGITS = 4;

    typedef logic [4:0] code_t;
    typedef logic [7:0] char_t;

    // Digit codes
    localparam code_t CODE_DASH  = 5'd10;
    localparam code_t CODE_BLANK = 5'd11;
    localparam code_t CODE_UNDER = 5'd13;
    localparam code_t CODE_EIGHT = 5'd8;

    // Characters
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_T      = 8'h54;
    localparam char_t CH_K      = 8'h4B;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_DASH   = 8'h2D;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_ONE    = 8'h31;
    localparam char_t CH_NINE   = 8'h39;
    localparam char_t CH_FILLER = 8'h20;

    // Configuration register indexes
    localparam logic [1:0] REG_ANIM_LIMIT = 2'd0;
    localparam logic [1:0] REG_LEFT_DOT   = 2'd1;
    localparam logic [1:0] REG_RIGHT_DOT  = 2'd2;

    localparam logic [7:0] ANIM_LIMIT_RESET = 8'd30;

    // Active-high segments C0-C5 for each digit code
    function automatic logic [5:0] seg_c(input code_t code);
        logic [5:0] s;
        unique case (code)
            5'd0:    s = 6'h2D;
            5'd1:    s = 6'h24;
            5'd2:    s = 6'h39;
            5'd3:    s = 6'h3C;
            5'd4:    s = 6'h34;
            5'd5:    s = 6'h1C;
            5'd6:    s = 6'h1D;
            5'd7:    s = 6'h24;
            5'd8:    s = 6'h3D;
            5'd9:    s = 6'h3C;
            5'd10:   s = 6'h10;
            5'd13:   s = 6'h08;
            5'd15:   s = 6'h01;
            5'd16:   s = 6'h20;
            5'd17:   s = 6'h04;
            default: s = 6'h00;
        endcase
        return s;
    endfunction

    // Active-high segments A4 (bit 0) and A5 (bit 1) for each digit code
    function automatic logic [1:0] seg_a(input code_t code);
        logic [1:0] s;
        unique case (code)
            5'd0, 5'd5, 5'd6, 5'd8, 5'd9:                     s = 2'b10;
            5'd1, 5'd10, 5'd11, 5'd13, 5'd15, 5'd16, 5'd17:    s = 2'b01;
            5'd4, 5'd14:                                      s = 2'b11;
            default:                                          s = 2'b00;
        endcase
        return s;
    endfunction

    // Animation: digit lit in each phase
    function automatic logic [1:0] anim_pos(input logic [3:0] phase);
        logic [1:0] p;
        unique case (phase)
            4'd0, 4'd13, 4'd14, 4'd15: p = 2'd0;
            4'd1, 4'd2, 4'd11, 4'd12:  p = 2'd1;
            4'd3, 4'd4, 4'd9, 4'd10:   p = 2'd2;
            default:                   p = 2'd3;
        endcase
        return p;
    endfunction

    // Animation: code shown in each phase
    function automatic code_t anim_code(input logic [3:0] phase);
        code_t c;
        unique case (phase)
            4'd0, 4'd1, 4'd8, 4'd9:    c = 5'd13;
            4'd2, 4'd7:                c = 5'd17;
            4'd3, 4'd14:               c = 5'd14;
            4'd4, 4'd5, 4'd12, 4'd13:  c = 5'd12;
            4'd6, 4'd11:               c = 5'd16;
            default:                   c = 5'd15;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/sl7seg_in_if.sv =====
// Input channel: one received byte or one millisecond tick per word.
interface sl7seg_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== sv/sl7seg_out_if.sv =====
// Output channel: display drive for one multiplexed digit per word.
interface sl7seg_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_index;
    logic [3:0] digit_enable_n;
    logic [5:0] seg_low_n;
    logic [1:0] seg_high_n;

    modport source (output valid, output digit_index, output digit_enable_n,
                    output seg_low_n, output seg_high_n, input ready);
    modport sink   (input valid, input digit_index, input digit_enable_n,
                    input seg_low_n, input seg_high_n, output ready);
endinterface

// ===== sv/serial_line_to_seven_segment_display_top.sv =====
// Serial line parser and four-digit multiplexed seven-segment driver.
//
// in_ch carries words of two kinds: cmd 0 is a received serial byte, cmd 1 a
// millisecond tick. Bytes update the line parser and the digit codes and give
// no output word. Each tick advances the animation while it runs and gives one
// output word on out_ch: the active-low select and segment drive of the next
// digit in the scan.
// The drive for a tick appears on out_ch in the cycle after the tick is accepted.
// One word per cycle is sustained while out_ch is ready: the single
// output register frees up in the same cycle that out_ch takes its word.
// If out_ch stalls with a word held, in_ch is not ready until that word
// leaves; the held word stays unchanged.
// Reset shows code 8 on all digits, starts the animation, clears the parser
// and the scan position, and loads anim_limit 30 with both end dots off.
// cfg_we writes register cfg_index (0 anim_limit, 1 left dot, 2 right dot)
// from cfg_data at the clock edge; index 3 is ignored.
module serial_line_to_seven_segment_display_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    sl7seg_in_if.sink           in_ch,
    sl7seg_out_if.source        out_ch
);
    import sl7seg_pkg::*;

    localparam logic [1:0] PH_SEEK    = 2'd0;
    localparam logic [1:0] PH_SKIP    = 2'd1;
    localparam logic [1:0] PH_CAPTURE = 2'd2;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_T    = 2'd1;
    localparam logic [1:0] CMD_K    = 2'd2;

    // Configuration
    logic [7:0] anim_limit_reg;
    logic       left_dot_reg;
    logic       right_dot_reg;

    // Display and parser state
    code_t      digit_codes_reg [DIGITS];
    code_t      digit_codes_next [DIGITS];
    char_t      captured_reg [DIGITS];
    char_t      captured_next [DIGITS];
    logic [1:0] parse_phase_reg, parse_phase_next;
    logic [1:0] command_kind_reg, command_kind_next;
    logic [2:0] capture_count_reg, capture_count_next;
    logic       anim_running_reg, anim_running_next;
    logic [7:0] anim_ticks_reg, anim_ticks_next;
    logic [3:0] anim_phase_reg, anim_phase_next;
    logic [1:0] scan_digit_reg, scan_digit_next;
    logic       mark_on_reg, mark_on_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_index_reg, out_index_next;
    logic [3:0] out_enable_reg, out_enable_next;
    logic [5:0] out_low_reg, out_low_next;
    logic [1:0] out_high_reg, out_high_next;

    logic       accept;
    logic       tick;
    char_t      b;
    code_t      t_codes [DIGITS];
    code_t      j_codes [DIGITS];
    logic       stop;
    char_t      c;
    logic [7:0] ticks_inc;
    code_t      shown;
    logic       dot;
    logic [5:0] segc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign tick        = in_ch.cmd;
    assign b           = in_ch.rx_byte;

    // Decode a T line into right-justified codes
    always_comb
    begin
        t_codes = digit_codes_reg;
        stop    = 1'b0;
        c       = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (!stop)
            begin
                c = captured_reg[k];
                if (3'(k) >= capture_count_reg)
                begin
                    t_codes[k] = CODE_BLANK;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    t_codes[k] = 5'(c - CH_ZERO);
                end
                else if (c == CH_COMMA)
                begin
                    // comma fills underscores from its digit to the right (at digit 0, only digit 3) and ends the scan
                    if (k == 1)
                    begin
                        t_codes[1] = CODE_UNDER;
                        t_codes[2] = CODE_UNDER;
                        t_codes[3] = CODE_UNDER;
                    end
                    else if (k == 2)
                    begin
                        t_codes[2] = CODE_UNDER;
                        t_codes[3] = CODE_UNDER;
                    end
                    else
                    begin
                        t_codes[3] = CODE_UNDER;
                    end
                    stop = 1'b1;
                end
                else if (c == CH_DASH)
                begin
                    t_codes[k] = CODE_DASH;
                end
                else
                begin
                    t_codes[k] = CODE_UNDER;
                end
            end
        end

        j_codes = t_codes;
        priority if (t_codes[1] == CODE_BLANK)
        begin
            j_codes[3] = t_codes[0];
            j_codes[2] = CODE_BLANK;
            j_codes[1] = CODE_BLANK;
            j_codes[0] = CODE_BLANK;
        end
        else if (t_codes[2] == CODE_BLANK)
        begin
            j_codes[3] = t_codes[1];
            j_codes[2] = t_codes[0];
            j_codes[1] = CODE_BLANK;
            j_codes[0] = CODE_BLANK;
        end
        else if (t_codes[3] == CODE_BLANK)
        begin
            j_codes[3] = t_codes[2];
            j_codes[2] = t_codes[1];
            j_codes[1] = t_codes[0];
            j_codes[0] = CODE_BLANK;
        end
        else
        begin
            // full line: keep it as decoded
            j_codes = t_codes;
        end
    end

    // Next state for one accepted word
    always_comb
    begin
        digit_codes_next   = digit_codes_reg;
        captured_next      = captured_reg;
        parse_phase_next   = parse_phase_reg;
        command_kind_next  = command_kind_reg;
        capture_count_next = capture_count_reg;
        anim_running_next  = anim_running_reg;
        anim_ticks_next    = anim_ticks_reg;
        anim_phase_next    = anim_phase_reg;
        scan_digit_next    = scan_digit_reg;
        mark_on_next       = mark_on_reg;
        ticks_inc          = anim_ticks_reg + 8'd1;

        if (accept && !tick)
        begin
            if (b == CH_CR)
            begin
                if (command_kind_reg == CMD_T)
                begin
                    digit_codes_next  = j_codes;
                    anim_running_next = 1'b0;
                end
                else if (command_kind_reg == CMD_K)
                begin
                    mark_on_next = (capture_count_reg != 3'd0) && (captured_reg[0] == CH_ONE);
                end
                parse_phase_next   = PH_SEEK;
                command_kind_next  = CMD_NONE;
                capture_count_next = 3'd0;
                for (int k = 0; k < DIGITS; k++)
                begin
                    captured_next[k] = CH_FILLER;
                end
            end
            else
            begin
                unique case (parse_phase_reg)
                    PH_SEEK:
                    begin
                        if (b == CH_T)
                        begin
                            command_kind_next = CMD_T;
                            parse_phase_next  = PH_SKIP;
                        end
                        else if (b == CH_K)
                        begin
                            command_kind_next = CMD_K;
                            parse_phase_next  = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        parse_phase_next = PH_CAPTURE;
                    end
                    default:
                    begin
                        // drop bytes once all digits are captured
                        if (capture_count_reg < 3'(DIGITS))
                        begin
                            captured_next[capture_count_reg[1:0]] = b;
                            capture_count_next = capture_count_reg + 3'd1;
                        end
                    end
                endcase
            end
        end

        if (accept && tick)
        begin
            if (anim_running_reg)
            begin
                anim_ticks_next = ticks_inc;
                if (ticks_inc > anim_limit_reg)
                begin
                    anim_ticks_next = 8'd0;
                    for (int k = 0; k < DIGITS; k++)
                    begin
                        digit_codes_next[k] = CODE_BLANK;
                    end
                    digit_codes_next[anim_pos(anim_phase_reg)] = anim_code(anim_phase_reg);
                    anim_phase_next = anim_phase_reg + 4'd1;
                end
            end
            scan_digit_next = scan_digit_reg + 2'd1;
        end
    end

    // Drive for the current scan digit, from the codes after this tick
    always_comb
    begin
        shown = digit_codes_next[scan_digit_reg];
        unique case (scan_digit_reg)
            2'd0:    dot = left_dot_reg;
            2'd3:    dot = right_dot_reg;
            default: dot = mark_on_reg;
        endcase
        segc = ~seg_c(shown);
        if (dot)
        begin
            segc[1] = 1'b0;
        end

        out_index_next  = out_index_reg;
        out_enable_next = out_enable_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        if (accept && tick)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = scan_digit_reg;
            out_enable_next = ~(4'b0001 << scan_digit_reg);
            out_low_next    = segc;
            out_high_next   = ~seg_a(shown);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_limit_reg    <= ANIM_LIMIT_RESET;
            left_dot_reg      <= 1'b0;
            right_dot_reg     <= 1'b0;
            for (int k = 0; k < DIGITS; k++)
            begin
                digit_codes_reg[k] <= CODE_EIGHT;
                captured_reg[k]    <= CH_FILLER;
            end
            parse_phase_reg   <= PH_SEEK;
            command_kind_reg  <= CMD_NONE;
            capture_count_reg <= 3'd0;
            anim_running_reg  <= 1'b1;
            anim_ticks_reg    <= 8'd0;
            anim_phase_reg    <= 4'd0;
            scan_digit_reg    <= 2'd0;
            mark_on_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ANIM_LIMIT: anim_limit_reg <= cfg_data;
                    REG_LEFT_DOT:   left_dot_reg   <= cfg_data[0];
                    REG_RIGHT_DOT:  right_dot_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end
            digit_codes_reg   <= digit_codes_next;
            captured_reg      <= captured_next;
            parse_phase_reg   <= parse_phase_next;
            command_kind_reg  <= command_kind_next;
            capture_count_reg <= capture_count_next;
            anim_running_reg  <= anim_running_next;
            anim_ticks_reg    <= anim_ticks_next;
            anim_phase_reg    <= anim_phase_next;
            scan_digit_reg    <= scan_digit_next;
            mark_on_reg       <= mark_on_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload holds while stalled
    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_enable_reg <= out_enable_next;
        out_low_reg    <= out_low_next;
        out_high_reg   <= out_high_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.digit_index    = out_index_reg;
    assign out_ch.digit_enable_n = out_enable_reg;
    assign out_ch.seg_low_n      = out_low_reg;
    assign out_ch.seg_high_n     = out_high_reg;

endmodule
